### sv/vnwi_pkg.sv
// shared types, constants and helper functions for the wedge corner finder
package vnwi_pkg;

  localparam int unsigned POINT_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned LAST_W  = 12;
  localparam int unsigned DATA_W  = 32;

  localparam logic [COUNT_W-1:0] POINTS_RESET = 11'd1024;

  localparam logic CFG_POINTS_THIS = 1'b0;
  localparam logic CFG_POINTS_NEXT = 1'b1;

  localparam logic ACT_WRITE = 1'b0;

  typedef enum logic [1:0] {
    K_WRITE,
    K_QUERY,
    K_QERR
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_PASS1,
    ST_PASS2,
    ST_RESULT
  } back_st_e;

  typedef struct packed {
    logic               action;
    logic               frame_select;
    logic [POINT_W-1:0] point_index;
    logic               valid_bit;
  } in_word_t;

  typedef struct packed {
    logic [POINT_W-1:0] this_a;
    logic [POINT_W-1:0] this_b;
    logic [POINT_W-1:0] next_a;
    logic [POINT_W-1:0] next_b;
    logic [POINT_W-1:0] this_a_compact;
    logic [POINT_W-1:0] this_b_compact;
    logic [POINT_W-1:0] next_a_compact;
    logic [POINT_W-1:0] next_b_compact;
    logic               index_error;
  } out_word_t;

  typedef struct packed {
    kind_e              kind;
    logic               sel;
    logic               vbit;
    logic [POINT_W-1:0] idx;
    logic [LAST_W-1:0]  last_this;
    logic [LAST_W-1:0]  last_next;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic init;
    logic p1;
    logic fin;
    logic p2;
  } scan_ctl_t;

  function automatic logic [4:0] msb_pos(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] v;
    logic [4:0]        p;
    v = x;
    p = '0;
    if (v[31:16] != '0) begin p[4] = 1'b1; v = v >> 16; end
    if (v[15:8] != '0) begin p[3] = 1'b1; v = v >> 8; end
    if (v[7:4] != '0) begin p[2] = 1'b1; v = v >> 4; end
    if (v[3:2] != '0) begin p[1] = 1'b1; v = v >> 2; end
    if (v[1]) begin p[0] = 1'b1; end
    return p;
  endfunction

  function automatic logic [4:0] lsb_pos(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] v;
    logic [4:0]        p;
    v = x;
    p = '0;
    if (v[15:0] == '0) begin p[4] = 1'b1; v = v >> 16; end
    if (v[7:0] == '0) begin p[3] = 1'b1; v = v >> 8; end
    if (v[3:0] == '0) begin p[2] = 1'b1; v = v >> 4; end
    if (v[1:0] == '0) begin p[1] = 1'b1; v = v >> 2; end
    if (!v[0]) begin p[0] = 1'b1; end
    return p;
  endfunction

  function automatic logic [5:0] popcount32(input logic [DATA_W-1:0] x);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 6'(x[4*i]) + 6'(x[4*i+1]) + 6'(x[4*i+2]) + 6'(x[4*i+3]);
    end
    return c;
  endfunction

endpackage

### sv/vnwi_ram.sv
// generic single write, single read ram with registered read data
module vnwi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vnwi_front.sv
// input side: accepts words, classifies them and queues decoded commands
module vnwi_front #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vnwi_pkg::in_word_t    in_word_i,
  input  logic [10:0]           points_this_i,
  input  logic [10:0]           points_next_i,
  input  vnwi_pkg::back_stat_t  stat_i,
  output logic                  head_valid_o,
  output vnwi_pkg::cmd_t        head_o
);

  import vnwi_pkg::*;

  localparam logic [12:0] MaxP = 13'(MAX_POINTS);

  function automatic logic [12:0] eff_count(input logic [COUNT_W-1:0] n);
    logic [12:0] e;
    e = 13'(n);
    if (n == '0) e = 13'd1;
    else if (e > MaxP) e = MaxP;
    return e;
  endfunction

  cmd_t        q_mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [12:0] nt, nn;
  logic        keep, push, acc;
  cmd_t        cmd;

  always_comb begin
    nt = eff_count(points_this_i);
    nn = eff_count(points_next_i);
    cmd.sel       = in_word_i.frame_select;
    cmd.vbit      = in_word_i.valid_bit;
    cmd.idx       = in_word_i.point_index;
    cmd.last_this = 12'(nt - 13'd1);
    cmd.last_next = 12'(nn - 13'd1);
    keep          = 1'b1;
    if (in_word_i.action == ACT_WRITE) begin
      cmd.kind = K_WRITE;
      // writes past the map are dropped
      keep = (13'(in_word_i.point_index) < MaxP);
    end else if (13'(in_word_i.point_index) >= nt - 13'd1) begin
      cmd.kind = K_QERR;
    end else begin
      cmd.kind = K_QUERY;
    end
  end

  assign in_stall_o   = (cnt_q == 2'd2) || stat_i.clearing;
  assign acc          = in_valid_i && !in_stall_o;
  assign push         = acc && keep;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = stat_i.pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(stat_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd;
    end
  end

endmodule

### sv/vnwi_scan.sv
// corner search and prefix count over one map, fed one 32-bit word a cycle
module vnwi_scan #(
  parameter int unsigned IW = 10,
  parameter int unsigned AW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vnwi_pkg::scan_ctl_t  ctl_i,
  input  logic [31:0]          word_i,
  input  logic [AW-1:0]        pw_i,
  input  logic [IW-1:0]        sa_i,
  input  logic [IW-1:0]        last_i,
  output logic [IW-1:0]        a_o,
  output logic [IW-1:0]        b_o,
  output logic [IW-1:0]        ca_o,
  output logic [IW-1:0]        cb_o
);

  import vnwi_pkg::*;

  // bits of word w at or below v
  function automatic logic [31:0] mask_le(input logic [IW-1:0] v, input logic [AW-1:0] w);
    logic [AW-1:0] wv;
    logic [31:0]   m;
    wv = AW'(v >> 5);
    if (w < wv) m = '1;
    else if (w == wv) m = 32'hFFFF_FFFF >> (5'd31 - v[4:0]);
    else m = '0;
    return m;
  endfunction

  // bits of word w strictly below v
  function automatic logic [31:0] mask_lt(input logic [IW-1:0] v, input logic [AW-1:0] w);
    logic [AW-1:0] wv;
    logic [31:0]   m;
    wv = AW'(v >> 5);
    if (w < wv) m = '1;
    else if (w == wv) m = (32'd1 << v[4:0]) - 32'd1;
    else m = '0;
    return m;
  endfunction

  logic [IW-1:0] sa_c, sb, sb_c, base;
  logic [31:0]   m, la, ha, hb, lb;
  logic [IW-1:0] lo_a_q, hi_a_q, hi_b_q, lo_b_q;
  logic          lo_a_f_q, hi_a_f_q, hi_b_f_q, lo_b_f_q;
  logic [IW-1:0] a_q, b_q, ca_q, cb_q;

  always_comb begin
    sb   = sa_i + IW'(1);
    sa_c = (sa_i > last_i) ? last_i : sa_i;
    sb_c = (sb > last_i) ? last_i : sb;
    base = IW'({pw_i, 5'd0});
    m    = word_i & mask_le(last_i, pw_i);
    la   = m & mask_le(sa_c, pw_i);
    ha   = m & ~mask_le(sa_c, pw_i);
    lb   = m & mask_lt(sb_c, pw_i);
    hb   = m & ~mask_lt(sb_c, pw_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_a_f_q <= 1'b0;
      hi_a_f_q <= 1'b0;
      hi_b_f_q <= 1'b0;
      lo_b_f_q <= 1'b0;
    end else if (ctl_i.init) begin
      lo_a_f_q <= 1'b0;
      hi_a_f_q <= 1'b0;
      hi_b_f_q <= 1'b0;
      lo_b_f_q <= 1'b0;
    end else if (ctl_i.p1) begin
      if (la != '0) lo_a_f_q <= 1'b1;
      if (ha != '0) hi_a_f_q <= 1'b1;
      if (hb != '0) hi_b_f_q <= 1'b1;
      if (lb != '0) lo_b_f_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.p1) begin
      // later words hold the nearer point below, the first hit above wins
      if (la != '0) lo_a_q <= base | IW'(msb_pos(la));
      if (lb != '0) lo_b_q <= base | IW'(msb_pos(lb));
      if (ha != '0 && !hi_a_f_q) hi_a_q <= base | IW'(lsb_pos(ha));
      if (hb != '0 && !hi_b_f_q) hi_b_q <= base | IW'(lsb_pos(hb));
    end
    if (ctl_i.fin) begin
      a_q  <= lo_a_f_q ? lo_a_q : (hi_a_f_q ? hi_a_q : last_i);
      b_q  <= hi_b_f_q ? hi_b_q : (lo_b_f_q ? lo_b_q : '0);
      ca_q <= '0;
      cb_q <= '0;
    end else if (ctl_i.p2) begin
      ca_q <= ca_q + IW'(popcount32(word_i & mask_lt(a_q, pw_i)));
      cb_q <= cb_q + IW'(popcount32(word_i & mask_lt(b_q, pw_i)));
    end
  end

  assign a_o  = a_q;
  assign b_o  = b_q;
  assign ca_o = ca_q;
  assign cb_o = cb_q;

endmodule

### sv/vnwi_back.sv
// execution side: map memories, clearing pass, bit writes and two-pass query sweep
module vnwi_back #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  vnwi_pkg::cmd_t        head_i,
  output vnwi_pkg::back_stat_t  stat_o,
  output logic                  res_valid_o,
  output vnwi_pkg::out_word_t   res_o,
  input  logic                  res_take_i
);

  import vnwi_pkg::*;

  localparam int unsigned WORDS = (MAX_POINTS + 31) / 32;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned IW    = ($clog2(MAX_POINTS) < 6) ? 6 : $clog2(MAX_POINTS);
  localparam logic [CW-1:0] EndCnt   = CW'(WORDS);
  localparam logic [CW-1:0] ClearEnd = CW'(WORDS - 1);

  back_st_e       st_q, st_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  cmd_t           cur_q, cur_d;
  logic           we_t, we_n;
  logic [AW-1:0]  raddr, waddr, pw;
  logic [31:0]    wdata, rd_t, rd_n;
  scan_ctl_t      ctl;
  logic [IW-1:0]  ta, tb, na, nb, tca, tcb, nca, ncb;

  vnwi_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram_this (
    .clk_i, .we_i(we_t), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rd_t)
  );

  vnwi_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram_next (
    .clk_i, .we_i(we_n), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rd_n)
  );

  assign pw = AW'(cnt_q - CW'(1));

  vnwi_scan #(.IW(IW), .AW(AW)) u_scan_this (
    .clk_i, .rst_ni, .ctl_i(ctl), .word_i(rd_t), .pw_i(pw),
    .sa_i(IW'(cur_q.idx)), .last_i(IW'(cur_q.last_this)),
    .a_o(ta), .b_o(tb), .ca_o(tca), .cb_o(tcb)
  );

  vnwi_scan #(.IW(IW), .AW(AW)) u_scan_next (
    .clk_i, .rst_ni, .ctl_i(ctl), .word_i(rd_n), .pw_i(pw),
    .sa_i(IW'(cur_q.idx)), .last_i(IW'(cur_q.last_next)),
    .a_o(na), .b_o(nb), .ca_o(nca), .cb_o(ncb)
  );

  always_comb begin
    st_d            = st_q;
    cnt_d           = cnt_q;
    cur_d           = cur_q;
    stat_o.pop      = 1'b0;
    stat_o.clearing = (st_q == ST_CLEAR);
    raddr           = cnt_q[AW-1:0];
    waddr           = cnt_q[AW-1:0];
    wdata           = '0;
    we_t            = 1'b0;
    we_n            = 1'b0;
    ctl             = '0;
    res_valid_o     = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        we_t  = 1'b1;
        we_n  = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == ClearEnd) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // fetch the word a write will modify
        raddr = AW'(head_i.idx >> 5);
        if (head_valid_i) begin
          stat_o.pop = 1'b1;
          cur_d      = head_i;
          cnt_d      = '0;
          case (head_i.kind)
            K_WRITE: st_d = ST_WRITE;
            K_QUERY: begin
              ctl.init = 1'b1;
              st_d     = ST_PASS1;
            end
            default: st_d = ST_RESULT;
          endcase
        end
      end
      ST_WRITE: begin
        waddr                 = AW'(cur_q.idx >> 5);
        wdata                 = cur_q.sel ? rd_n : rd_t;
        wdata[cur_q.idx[4:0]] = cur_q.vbit;
        we_t                  = !cur_q.sel;
        we_n                  = cur_q.sel;
        st_d                  = ST_IDLE;
      end
      ST_PASS1: begin
        ctl.p1 = (cnt_q != '0);
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == EndCnt) begin
          cnt_d = '0;
          st_d  = ST_PASS2;
        end
      end
      ST_PASS2: begin
        ctl.fin = (cnt_q == '0);
        ctl.p2  = (cnt_q != '0);
        cnt_d   = cnt_q + CW'(1);
        if (cnt_q == EndCnt) begin
          cnt_d = '0;
          st_d  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_take_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (cur_q.kind == K_QERR) begin
      res_o.index_error = 1'b1;
    end else begin
      res_o.this_a         = POINT_W'(ta);
      res_o.this_b         = POINT_W'(tb);
      res_o.next_a         = POINT_W'(na);
      res_o.next_b         = POINT_W'(nb);
      res_o.this_a_compact = POINT_W'(tca);
      res_o.this_b_compact = POINT_W'(tcb);
      res_o.next_a_compact = POINT_W'(nca);
      res_o.next_b_compact = POINT_W'(ncb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

`ifndef NO_ASSERTIONS
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.pop |-> head_valid_i) else $error("pop from empty queue");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> !stat_o.pop) else $error("pop during clearing pass");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_take_i |=> st_q == ST_IDLE) else $error("result not retired");
  a_no_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PASS1 || st_q == ST_PASS2) |-> !(we_t || we_n))
    else $error("map write during sweep");
`endif

endmodule

### sv/valid_neighbor_wedge_index_core.sv
// top level: config registers, front and back halves, output register
// write word: read-modify-write in the back half; query: two word-per-cycle sweeps
// over the map memories, W = ceil(MAX_POINTS/32) words each; index-error query: no sweep
// a two-entry command queue decouples input from execution
// after reset a clearing pass over all W words zeroes both maps while input is stalled
// config registers reset to 1024 points per frame
module valid_neighbor_wedge_index_core #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [10:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vnwi_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vnwi_pkg::out_word_t  out_word_o
);

  import vnwi_pkg::*;

  logic [COUNT_W-1:0] points_this_q, points_next_q;
  back_stat_t         stat;
  logic               head_valid, res_valid, res_take;
  cmd_t               head;
  out_word_t          res, out_q;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_this_q <= POINTS_RESET;
      points_next_q <= POINTS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_POINTS_THIS) points_this_q <= cfg_data_i;
      if (cfg_index_i == CFG_POINTS_NEXT) points_next_q <= cfg_data_i;
    end
  end

  vnwi_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .points_this_i(points_this_q), .points_next_i(points_next_q),
    .stat_i(stat), .head_valid_o(head_valid), .head_o(head)
  );

  vnwi_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head), .stat_o(stat),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(res_take)
  );

  // output register frees up when its word leaves
  assign res_take    = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_take ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### verif/valid_neighbor_wedge_index_core_tb.sv
// testbench for the wedge corner finder: directed and random words against a local predictor
`timescale 1ns / 100ps

module valid_neighbor_wedge_index_core_tb;
  import vnwi_pkg::*;

  localparam int NPTS = 1024;
  localparam int WD_LIMIT = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_index_i = CFG_POINTS_THIS;
  logic [10:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  valid_neighbor_wedge_index_core #(.MAX_POINTS(NPTS)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  bit        cur_map [NPTS];
  bit        nxt_map [NPTS];
  logic [10:0] cnt_this = POINTS_RESET;
  logic [10:0] cnt_next = POINTS_RESET;
  out_word_t corner_q [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        queries_sent = 0;
  int        writes_sent = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b1;
  bit        timed_out = 1'b0;

  function automatic int used_count(logic [10:0] n);
    if (n == 0) return 1;
    if (n > NPTS) return NPTS;
    return n;
  endfunction

  function automatic int below(bit which, int pos);
    int c;
    c = 0;
    for (int k = 0; k < pos; k++) c += which ? nxt_map[k] : cur_map[k];
    return c;
  endfunction

  function automatic void walk(bit which, int last, int sa, int sb,
                               output int ra, output int rb);
    int a, b;
    a = sa > last ? last : sa;
    b = sb > last ? last : sb;
    while (!(which ? nxt_map[a] : cur_map[a]) && a > 0) a--;
    while (!(which ? nxt_map[a] : cur_map[a]) && a < last) a++;
    while (!(which ? nxt_map[b] : cur_map[b]) && b < last) b++;
    while (!(which ? nxt_map[b] : cur_map[b]) && b > 0) b--;
    ra = a;
    rb = b;
  endfunction

  function automatic void predict_word(in_word_t w);
    out_word_t r;
    int nt, nn, ta, tb, na, nb, i;
    if (w.action == ACT_WRITE) begin
      if (w.frame_select) nxt_map[w.point_index] = w.valid_bit;
      else cur_map[w.point_index] = w.valid_bit;
      return;
    end
    r = '0;
    i = w.point_index;
    nt = used_count(cnt_this);
    nn = used_count(cnt_next);
    if (i >= nt - 1) begin
      r.index_error = 1'b1;
    end else begin
      walk(1'b0, nt - 1, i, i + 1, ta, tb);
      walk(1'b1, nn - 1, i, i + 1, na, nb);
      r.this_a = POINT_W'(ta); r.this_b = POINT_W'(tb);
      r.next_a = POINT_W'(na); r.next_b = POINT_W'(nb);
      r.this_a_compact = POINT_W'(below(1'b0, ta));
      r.this_b_compact = POINT_W'(below(1'b0, tb));
      r.next_a_compact = POINT_W'(below(1'b1, na));
      r.next_b_compact = POINT_W'(below(1'b1, nb));
    end
    corner_q = {corner_q, r};
  endfunction

  task automatic send_word(in_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w);
    if (w.action == ACT_WRITE) writes_sent++;
    else queries_sent++;
    @(negedge clk_i);
  endtask

  task automatic put(int act, int sel, int idx, int vb);
    in_word_t w;
    w.action = 1'(act);
    w.frame_select = 1'(sel);
    w.point_index = POINT_W'(idx);
    w.valid_bit = 1'(vb);
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (corner_q.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic set_counts(int t, int n);
    drain();
    cfg_we_i <= 1'b1; cfg_index_i <= CFG_POINTS_THIS; cfg_data_i <= 11'(t);
    @(negedge clk_i);
    cfg_index_i <= CFG_POINTS_NEXT; cfg_data_i <= 11'(n);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cnt_this = 11'(t);
    cnt_next = 11'(n);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (corner_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word_o);
      end else if (corner_q[0] !== out_word_o) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p actual %p", corner_q[0], out_word_o);
        void'(corner_q.pop_front());
      end else begin
        void'(corner_q.pop_front());
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      timed_out = 1'b1;
      $display("valid_neighbor_wedge_index_core_tb failed");
      $finish;
    end
  end

  task automatic test_empty_maps();
    put(1, 0, 0, 0);
    put(1, 1, 511, 1);
    put(1, 0, 1022, 0);
    put(1, 0, 1023, 0);
  endtask

  task automatic test_directed();
    put(0, 0, 0, 1);
    put(0, 0, 1023, 1);
    put(0, 1, 500, 1);
    put(1, 0, 0, 0);
    put(1, 0, 600, 0);
    put(1, 0, 1022, 0);
    put(0, 0, 0, 0);
    put(1, 0, 3, 0);
    put(0, 1, 500, 0);
    put(0, 1, 1023, 1);
    put(1, 1, 200, 1);
    put(0, 0, 1023, 0);
  endtask

  task automatic test_short_frames();
    put(0, 1, 2, 1);
    set_counts(0, 0);
    put(1, 0, 0, 0);
    set_counts(2, 3);
    put(1, 0, 0, 0);
    put(1, 0, 1, 0);
    set_counts(2047, 1);
    put(1, 0, 700, 0);
    put(1, 0, 1023, 0);
    set_counts(50, 20);
    put(1, 0, 48, 0);
    put(1, 0, 10, 0);
  endtask

  task automatic test_random(int n, int t, int m, int density);
    set_counts(t, m);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 60)
        put(0, $urandom_range(0, 1), $urandom_range(0, 1023),
            $urandom_range(0, 99) < density);
      else if ($urandom_range(0, 9) == 0)
        put(1, $urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1));
      else
        put(1, $urandom_range(0, 1), $urandom_range(0, used_count(11'(t)) + 1),
            $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_maps();
    test_directed();
    test_short_frames();
    test_random(400, 1024, 1024, 50);
    drain();
    test_random(400, 64, 40, 10);
    test_random(400, 1024, 300, 3);
    test_random(350, 1, 1024, 70);
    gaps_on = 1'b0;
    test_random(400, 200, 1024, 30);
    drain();
    $display("covered %0d writes and %0d queries, %0d results checked",
             writes_sent, queries_sent, results_seen);
    $display("frame counts swept from 0 to 2047, sparse, dense and empty maps");
    if (mismatches == 0 && corner_q.size() == 0)
      $display("valid_neighbor_wedge_index_core_tb passed");
    else
      $display("valid_neighbor_wedge_index_core_tb failed");
    $finish;
  end

endmodule

### filelist.f
sv/vnwi_pkg.sv
sv/vnwi_ram.sv
sv/vnwi_front.sv
sv/vnwi_scan.sv
sv/vnwi_back.sv
sv/valid_neighbor_wedge_index_core.sv
verif/valid_neighbor_wedge_index_core_tb.sv
